/* hw/rtl/slrt_pkg.sv */
// shared constants for the spot light reach test pipeline
`timescale 1ns / 1ps
package slrt_pkg;

  // operand slice width of the pipelined wide multiplier
  localparam int unsigned MulChunkW = 16;
  // register stages through the wide multiplier
  localparam int unsigned MulLatency = 3;
  // square root digits resolved in each pipeline stage
  localparam int unsigned SqrtStepsPerStage = 4;

endpackage

/* hw/rtl/spot_light_reach_test.sv */
// spot light reach test: top level pipeline
`timescale 1ns / 1ps
//
// Decides, for one light and one point per request, whether the light can
// reach the point. The input channel carries the light (kind, origin,
// direction, radius, outer cosine, rotation limit) and the point; the output
// channel returns a single reaches bit per request, in order.
// Both channels use valid/stall: a request moves on a rising edge with valid
// high and stall low.
// Throughput: one request per cycle while the output is not stalled. The
// square root pipeline (four root bits per stage) is the longest part of
// the path; the rest is the delta, product, sum, root operand, cone cosine,
// cosine square, wide multiplier and output register stages.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall_o rises; bubbles drain while the output slot is empty.
// Reset clears all valid bits; no result is presented until new requests
// enter. The block keeps no state between requests.
//
module spot_light_reach_test #(
  parameter int unsigned COORD_WIDTH   = 24,
  parameter int unsigned COS_FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic signed [COORD_WIDTH-1:0] light_x_i,
  input  logic signed [COORD_WIDTH-1:0] light_y_i,
  input  logic signed [COORD_WIDTH-1:0] light_z_i,
  input  logic signed [COS_FRAC_BITS+1:0] dir_x_i,
  input  logic signed [COS_FRAC_BITS+1:0] dir_y_i,
  input  logic signed [COS_FRAC_BITS+1:0] dir_z_i,
  input  logic [COORD_WIDTH-2:0]        reach_radius_i,
  input  logic signed [COS_FRAC_BITS+1:0] cos_outer_i,
  input  logic signed [COS_FRAC_BITS+1:0] rotation_limit_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [2*COORD_WIDTH-1:0] point_y_and_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          reaches_o
);
  import slrt_pkg::*;

  localparam int unsigned C     = COORD_WIDTH;
  localparam int unsigned F     = COS_FRAC_BITS;
  localparam int unsigned DW    = C + 1;          // coordinate delta
  localparam int unsigned CW    = F + 2;          // cosine / direction
  localparam int unsigned TW    = DW + CW;        // one dot product term
  localparam int unsigned DOTW  = TW + 2;         // full dot product
  localparam int unsigned DMW   = DOTW - 1;       // dot magnitude
  localparam int unsigned DISTW = 2 * DW;         // squared distance
  localparam int unsigned RADW  = C - 1;
  localparam int unsigned RSQW  = 2 * RADW;
  localparam int unsigned SW    = 2 * F + 1;      // sine squared terms, root
  localparam int unsigned PW    = 2 * SW;         // product under the root
  localparam int unsigned CORW  = 2 * CW;         // cosine products
  localparam int unsigned CWW   = 2 * F + 3;      // widened cosine, Q.2F
  localparam int unsigned CMW   = 2 * F + 2;      // its magnitude
  localparam int unsigned CSQW  = 2 * CMW;
  localparam int unsigned CRW   = CMW + RADW;
  localparam int unsigned DSQW  = 2 * DMW;
  localparam int unsigned BIGW  = CSQW + DISTW;
  localparam int unsigned CAW   = (DMW + F > CRW) ? DMW + F : CRW;
  localparam int unsigned CBW   = (BIGW > DSQW + 2*F) ? BIGW : DSQW + 2*F;

  // pipeline positions
  localparam int unsigned NSQ   = (SW + SqrtStepsPerStage - 1) / SqrtStepsPerStage;
  localparam int unsigned K_SQ  = 4;              // root operand registered
  localparam int unsigned K_CW  = K_SQ + NSQ + 1; // widened cosine
  localparam int unsigned K_MI  = K_CW + 1;       // cosine square, cosine x radius
  localparam int unsigned K_END = K_MI + MulLatency;
  localparam int unsigned K_OUT = K_END + 1;

  localparam logic signed [CW-1:0]   CosOne = CW'(1) << F;
  localparam logic signed [CORW-1:0] CosOneSq = CORW'(1) << (2*F);
  localparam logic signed [CWW-1:0]  CwMax = CWW'(1) << (2*F);

  typedef struct packed {
    logic                    early;     // decided without the cone test
    logic                    early_res;
    logic                    rl_one;    // rotation limit is exactly one
    logic                    rad_zero;
    logic signed [DOTW-1:0]  dot;
    logic [DMW-1:0]          dmag;
    logic [DISTW-1:0]        dist_sq;
    logic [RADW-1:0]         rad;
    logic signed [CORW-1:0]  cor;
    logic signed [CWW-1:0]   cw;
    logic [CMW-1:0]          cmag;
    logic [CSQW-1:0]         cwsq;
    logic [CRW-1:0]          cwr;
  } side_t;

  function automatic logic signed [CW-1:0] clamp_cos(input logic signed [CW-1:0] c);
    logic signed [CW-1:0] r;
    r = c;
    if (c > CosOne) begin
      r = CosOne;
    end else if (c < -CosOne) begin
      r = -CosOne;
    end
    return r;
  endfunction

  logic en;
  logic vld_q [1:K_OUT];

  // stall the pipe only when a finished result is held by the receiver
  assign en         = !vld_q[K_OUT] || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= K_OUT; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[1] <= in_valid_i;
      for (int k = 2; k <= K_OUT; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage 1: deltas and clamped cosines
  logic signed [DW-1:0] dx_q, dy_q, dz_q;
  logic signed [CW-1:0] vx_q, vy_q, vz_q;
  logic signed [CW-1:0] co_q, rl_q;
  logic [RADW-1:0]      rad1_q;
  logic                 kind_q;
  logic signed [C-1:0]  py, pz;

  assign py = point_y_and_z_i[2*C-1:C];
  assign pz = point_y_and_z_i[C-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q   <= DW'(light_x_i) - DW'(point_x_i);
      dy_q   <= DW'(light_y_i) - DW'(py);
      dz_q   <= DW'(light_z_i) - DW'(pz);
      vx_q   <= dir_x_i;
      vy_q   <= dir_y_i;
      vz_q   <= dir_z_i;
      co_q   <= clamp_cos(cos_outer_i);
      rl_q   <= clamp_cos(rotation_limit_i);
      rad1_q <= reach_radius_i;
      kind_q <= kind_i;
    end
  end

  // stage 2: products
  logic signed [DISTW-1:0] sqx_q, sqy_q, sqz_q;
  logic signed [TW-1:0]    dpx_q, dpy_q, dpz_q;
  logic [RSQW-1:0]         rsq2_q;
  logic signed [CORW-1:0]  cosq_q, rlsq_q, cor2_q;
  logic [RADW-1:0]         rad2_q;
  logic                    wide2_q, rlone2_q;
  logic signed [CW:0]      cos_sum;

  // rotation limit at or below minus the outer cosine
  assign cos_sum = (CW+1)'(rl_q) + (CW+1)'(co_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q    <= dx_q * dx_q;
      sqy_q    <= dy_q * dy_q;
      sqz_q    <= dz_q * dz_q;
      dpx_q    <= dx_q * vx_q;
      dpy_q    <= dy_q * vy_q;
      dpz_q    <= dz_q * vz_q;
      rsq2_q   <= rad1_q * rad1_q;
      cosq_q   <= co_q * co_q;
      rlsq_q   <= rl_q * rl_q;
      cor2_q   <= co_q * rl_q;
      rad2_q   <= rad1_q;
      wide2_q  <= kind_q || (cos_sum <= 0);
      rlone2_q <= (rl_q == CosOne);
    end
  end

  // stage 3: sums and sine squares
  logic [DISTW-1:0]       dist3_q;
  logic signed [DOTW-1:0] dot3_q;
  logic [SW-1:0]          s0_q, s1_q;
  logic [RSQW-1:0]        rsq3_q;
  logic signed [CORW-1:0] cor3_q;
  logic [RADW-1:0]        rad3_q;
  logic                   wide3_q, rlone3_q;
  logic signed [CORW-1:0] s0_full, s1_full;

  assign s0_full = CosOneSq - cosq_q;
  assign s1_full = CosOneSq - rlsq_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist3_q  <= DISTW'(sqx_q) + DISTW'(sqy_q) + DISTW'(sqz_q);
      dot3_q   <= DOTW'(dpx_q) + DOTW'(dpy_q) + DOTW'(dpz_q);
      s0_q     <= s0_full[SW-1:0];
      s1_q     <= s1_full[SW-1:0];
      rsq3_q   <= rsq2_q;
      cor3_q   <= cor2_q;
      rad3_q   <= rad2_q;
      wide3_q  <= wide2_q;
      rlone3_q <= rlone2_q;
    end
  end

  // stage 4: radius test, root operand, side data enters its delay line
  logic [PW-1:0]          p_q;
  side_t                  side_q [K_SQ:K_END];
  side_t                  side4_d;
  logic                   outside;
  logic signed [DOTW-1:0] dot_neg;

  assign outside = dist3_q >= DISTW'(rsq3_q);
  assign dot_neg = -dot3_q;

  always_comb begin
    side4_d           = '0;
    side4_d.early     = outside || wide3_q;
    side4_d.early_res = !outside;
    side4_d.rl_one    = rlone3_q;
    side4_d.rad_zero  = (rad3_q == '0);
    side4_d.dot       = dot3_q;
    side4_d.dmag      = (dot3_q < 0) ? dot_neg[DMW-1:0] : dot3_q[DMW-1:0];
    side4_d.dist_sq   = dist3_q;
    side4_d.rad       = rad3_q;
    side4_d.cor       = cor3_q;
  end

  // square root of the sine product
  logic [SW-1:0] root;

  slrt_isqrt #(
    .VW (PW),
    .RW (SW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_i    (p_q),
    .root_o (root)
  );

  // widened cone cosine, aligned with the root output
  side_t                 cw_side, mi_side;
  logic signed [CWW-1:0] corx, cwv, cw_neg;

  assign corx   = CWW'(side_q[K_CW-1].cor);
  assign cwv    = side_q[K_CW-1].rl_one ? corx : corx - CWW'({1'b0, root});
  assign cw_neg = -cwv;

  always_comb begin
    cw_side      = side_q[K_CW-1];
    cw_side.cw   = cwv;
    cw_side.cmag = (cwv < 0) ? cw_neg[CMW-1:0] : cwv[CMW-1:0];
  end

  always_comb begin
    mi_side      = side_q[K_MI-1];
    mi_side.cwsq = side_q[K_MI-1].cmag * side_q[K_MI-1].cmag;
    mi_side.cwr  = CRW'(side_q[K_MI-1].cmag) * CRW'(side_q[K_MI-1].rad);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q          <= s0_q * s1_q;
      side_q[K_SQ] <= side4_d;
      for (int k = K_SQ + 1; k <= K_END; k++) begin
        if (k == K_CW) begin
          side_q[k] <= cw_side;
        end else if (k == K_MI) begin
          side_q[k] <= mi_side;
        end else begin
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  // wide products for the squared cone test
  logic [DSQW-1:0] dotsq;
  logic [BIGW-1:0] big;

  slrt_mul #(
    .AW (DMW),
    .BW (DMW)
  ) u_mul_dot (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (side_q[K_MI].dmag),
    .b_i   (side_q[K_MI].dmag),
    .p_o   (dotsq)
  );

  slrt_mul #(
    .AW (CSQW),
    .BW (DISTW)
  ) u_mul_cone (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (side_q[K_MI].cwsq),
    .b_i   (side_q[K_MI].dist_sq),
    .p_o   (big)
  );

  // final decision
  side_t           fin;
  logic            dot_pos;
  logic            res_direct, res_cone, res_d;
  logic [CAW-1:0]  lhs_a, rhs_a;
  logic [CBW-1:0]  lhs_b, rhs_b;

  assign fin     = side_q[K_END];
  assign dot_pos = fin.dot > 0;
  assign lhs_a   = CAW'({fin.dmag, {F{1'b0}}});
  assign rhs_a   = CAW'(fin.cwr);
  assign lhs_b   = CBW'(big);
  assign rhs_b   = CBW'({dotsq, {(2*F){1'b0}}});

  // non-positive widened cosine: direct comparison against cosine x radius
  assign res_direct = !dot_pos && (lhs_a >= rhs_a);
  // positive cosine: squared dot against distance
  assign res_cone   = dot_pos && (lhs_b <= rhs_b);

  always_comb begin
    if (fin.early) begin
      res_d = fin.early_res;
    end else if (!fin.rl_one && (fin.cw <= 0)) begin
      res_d = res_direct;
    end else begin
      res_d = res_cone;
    end
  end

  logic reaches_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      reaches_q <= res_d;
    end
  end

  assign out_valid_o = vld_q[K_OUT];
  assign reaches_o   = reaches_q;

`ifndef ASSERT_OFF
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_cw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[K_CW] |-> (side_q[K_CW].cw <= CwMax))
    else $error("widened cosine above one");

  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[K_SQ] && side_q[K_SQ].rad_zero) |->
      (side_q[K_SQ].early && !side_q[K_SQ].early_res))
    else $error("zero radius not rejected");
`endif

endmodule

/* hw/rtl/slrt_mul.sv */
// pipelined unsigned multiplier built from narrow partial products
`timescale 1ns / 1ps
module slrt_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [AW-1:0]      a_i,
  input  logic [BW-1:0]      b_i,
  output logic [AW+BW-1:0]   p_o
);
  import slrt_pkg::*;

  localparam int unsigned NA = (AW + MulChunkW - 1) / MulChunkW;
  localparam int unsigned NB = (BW + MulChunkW - 1) / MulChunkW;
  localparam int unsigned PW = (NA + NB) * MulChunkW;

  logic [NA*MulChunkW-1:0] a_pad;
  logic [NB*MulChunkW-1:0] b_pad;
  logic [2*MulChunkW-1:0]  pp_q [NA][NB];
  logic [PW-1:0]           row_d [NA];
  logic [PW-1:0]           row_q [NA];
  logic [PW-1:0]           sum_d;
  logic [PW-1:0]           sum_q;

  assign a_pad = (NA*MulChunkW)'(a_i);
  assign b_pad = (NB*MulChunkW)'(b_i);

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= (2*MulChunkW)'(a_pad[i*MulChunkW +: MulChunkW])
                      * (2*MulChunkW)'(b_pad[j*MulChunkW +: MulChunkW]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (PW'(pp_q[i][j]) << (j*MulChunkW));
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      sum_d = sum_d + (row_q[i] << (i*MulChunkW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q <= row_d;
      sum_q <= sum_d;
    end
  end

  assign p_o = sum_q[AW+BW-1:0];

endmodule

/* hw/rtl/slrt_isqrt.sv */
// pipelined integer square root, rounding down
`timescale 1ns / 1ps
module slrt_isqrt #(
  parameter int unsigned VW = 58,
  parameter int unsigned RW = 29
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [VW-1:0] v_i,
  output logic [RW-1:0] root_o
);
  import slrt_pkg::*;

  localparam int unsigned NS  = (RW + SqrtStepsPerStage - 1) / SqrtStepsPerStage;
  localparam int unsigned NI  = NS * SqrtStepsPerStage;
  localparam int unsigned XW  = 2 * NI;
  localparam int unsigned RMW = NI + 2;

  logic [RMW-1:0] rem_q  [NS];
  logic [NI-1:0]  root_q [NS];
  logic [XW-1:0]  x_q    [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [RMW-1:0] rem_in;
    logic [NI-1:0]  root_in;
    logic [XW-1:0]  x_in;
    logic [RMW-1:0] rem_d;
    logic [NI-1:0]  root_d;
    logic [XW-1:0]  x_d;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = XW'(v_i);
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign x_in    = x_q[s-1];
    end

    // restoring digit recurrence, two radicand bits per step
    always_comb begin
      logic [RMW-1:0] trial;
      rem_d  = rem_in;
      root_d = root_in;
      x_d    = x_in;
      trial  = '0;
      for (int j = 0; j < SqrtStepsPerStage; j++) begin
        rem_d = {rem_d[RMW-3:0], x_d[XW-1 -: 2]};
        x_d   = x_d << 2;
        trial = {root_d, 2'b01};
        if (rem_d >= trial) begin
          rem_d  = rem_d - trial;
          root_d = {root_d[NI-2:0], 1'b1};
        end else begin
          root_d = {root_d[NI-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        x_q[s]    <= x_d;
      end
    end
  end

  assign root_o = root_q[NS-1][RW-1:0];

endmodule

/* dv/tb_spot_light_reach_test.sv */
// testbench for the spot light reach test pipeline
`timescale 1ns / 1ps

module tb_spot_light_reach_test;

  localparam int CoordW   = 24;
  localparam int CosFrac  = 14;
  localparam int CosW     = CosFrac + 2;
  localparam longint CosOne = longint'(1) << CosFrac;
  localparam bit KindSpot = 1'b0;
  localparam bit KindOmni = 1'b1;
  // acceptance to out_valid_o, plus margin for drain at the end
  localparam int DrainCycles = 18 + 20;

  // one light/point request as it crosses the input channel
  typedef struct packed {
    logic                     kind;
    logic signed [CoordW-1:0] light_x;
    logic signed [CoordW-1:0] light_y;
    logic signed [CoordW-1:0] light_z;
    logic signed [CosW-1:0]   dir_x;
    logic signed [CosW-1:0]   dir_y;
    logic signed [CosW-1:0]   dir_z;
    logic [CoordW-2:0]        reach_radius;
    logic signed [CosW-1:0]   cos_outer;
    logic signed [CosW-1:0]   rotation_limit;
    logic signed [CoordW-1:0] point_x;
    logic [2*CoordW-1:0]      point_y_and_z;
  } reach_req_t;

  // queue of predicted reaches bits, checked in order
  class reach_scoreboard;
    bit pending_reach[$];
    int mismatches;
    int checked;

    function void note_request(bit predicted);
      pending_reach.push_back(predicted);
    endfunction

    function void check_result(bit actual);
      bit predicted;
      if (pending_reach.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result reaches=%0b", actual);
        return;
      end
      predicted = pending_reach.pop_front();
      checked++;
      if (predicted !== actual) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reaches mismatch #%0d: expected %0b actual %0b", checked, predicted, actual);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic reaches;
  reach_req_t req = '0;

  reach_scoreboard sb = new();
  bit no_idle = 1'b0;   // long burst with both sides always ready
  int n_sent;
  int n_omni;
  int n_wide;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  spot_light_reach_test u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .kind_i          (req.kind),
    .light_x_i       (req.light_x),
    .light_y_i       (req.light_y),
    .light_z_i       (req.light_z),
    .dir_x_i         (req.dir_x),
    .dir_y_i         (req.dir_y),
    .dir_z_i         (req.dir_z),
    .reach_radius_i  (req.reach_radius),
    .cos_outer_i     (req.cos_outer),
    .rotation_limit_i(req.rotation_limit),
    .point_x_i       (req.point_x),
    .point_y_and_z_i (req.point_y_and_z),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .reaches_o       (reaches)
  );

  // saturate a cosine to [-1, 1]
  function automatic longint sat_cos(logic signed [CosW-1:0] c);
    longint v;
    v = longint'(c);
    if (v > CosOne) return CosOne;
    if (v < -CosOne) return -CosOne;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 2 * CosFrac + 1; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // predicted reaches bit for one request
  function automatic bit light_reaches(reach_req_t r);
    longint dx, dy, dz, dist_sq, rad, dot, co, rl, wide_cos;
    longint unsigned s0, s1;
    logic [127:0] lhs, rhs, wabs, dabs;
    dx = longint'(r.light_x) - longint'(r.point_x);
    dy = longint'(r.light_y) - longint'($signed(r.point_y_and_z[2*CoordW-1:CoordW]));
    dz = longint'(r.light_z) - longint'($signed(r.point_y_and_z[CoordW-1:0]));
    dist_sq = dx * dx + dy * dy + dz * dz;
    rad = longint'(r.reach_radius);
    co = sat_cos(r.cos_outer);
    rl = sat_cos(r.rotation_limit);
    if (dist_sq >= rad * rad) return 1'b0;
    if (r.kind == KindOmni || rl <= -co) return 1'b1;
    dot = dx * longint'(r.dir_x) + dy * longint'(r.dir_y) + dz * longint'(r.dir_z);
    if (rl == CosOne) begin
      wide_cos = co * CosOne;
    end else begin
      s0 = CosOne * CosOne - co * co;
      s1 = CosOne * CosOne - rl * rl;
      wide_cos = co * rl - longint'(root_floor(s0 * s1));
      // cone opens past a half space: direct comparison against W * radius
      if (wide_cos <= 0) begin
        if (dot > 0) return 1'b0;
        lhs = 128'(-dot) << CosFrac;
        rhs = 128'(-wide_cos) * 128'(rad);
        return lhs >= rhs;
      end
    end
    if (dot <= 0) return 1'b0;
    wabs = 128'(wide_cos < 0 ? -wide_cos : wide_cos);
    dabs = 128'(dot);
    lhs = wabs * wabs * 128'(dist_sq);
    rhs = (dabs * dabs) << (2 * CosFrac);
    return lhs <= rhs;
  endfunction

  function automatic logic signed [CosW-1:0] rand_cos();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return CosW'(CosOne);
      1: return CosW'(-CosOne);
      2: return '0;
      3: return CosW'($urandom);   // raw bits, often beyond one
      default: return CosW'($urandom_range(0, 2 * CosOne) - CosOne);
    endcase
  endfunction

  function automatic logic signed [CoordW-1:0] rand_offset();
    int sel;
    sel = $urandom_range(0, 3);
    case (sel)
      0: return CoordW'($urandom);
      1: return CoordW'($urandom_range(0, 8191) - 4096);
      default: return CoordW'($urandom_range(0, 1 << 19) - (1 << 18));
    endcase
  endfunction

  // mostly points near the light so the cone tests are reached
  function automatic reach_req_t rand_request();
    reach_req_t r;
    logic signed [CoordW-1:0] py, pz;
    r.kind = ($urandom_range(0, 4) == 0) ? KindOmni : KindSpot;
    r.light_x = CoordW'($urandom);
    r.light_y = CoordW'($urandom);
    r.light_z = CoordW'($urandom);
    r.dir_x = rand_cos();
    r.dir_y = rand_cos();
    r.dir_z = rand_cos();
    r.cos_outer = rand_cos();
    case ($urandom_range(0, 5))
      0: r.rotation_limit = CosW'(CosOne);
      1: r.rotation_limit = -r.cos_outer;
      2: r.rotation_limit = CosW'(-r.cos_outer + 1);
      default: r.rotation_limit = rand_cos();
    endcase
    r.point_x = r.light_x - rand_offset();
    py = r.light_y - rand_offset();
    pz = r.light_z - rand_offset();
    r.point_y_and_z = {py, pz};
    case ($urandom_range(0, 5))
      0: r.reach_radius = '0;
      1: r.reach_radius = '1;
      2: r.reach_radius = (CoordW-1)'($urandom);
      default: r.reach_radius = (CoordW-1)'($urandom_range(1, 1 << 20));
    endcase
    return r;
  endfunction

  // present one request and hold it until accepted, then maybe idle
  task automatic send_request(reach_req_t r);
    int gap;
    req <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(light_reaches(r));
    n_sent++;
    if (r.kind == KindOmni) n_omni++;
    if (sat_cos(r.rotation_limit) <= -sat_cos(r.cos_outer)) n_wide++;
    if (!no_idle && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending_reach.size() != 0) @(posedge clk);
  endtask

  // receiver: check on accept, then choose next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(reaches);
    out_stall <= (!no_idle && $urandom_range(0, 99) < 33);
  end

  initial begin
    reach_req_t r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: light at the origin, unit direction along +x
    r = '0;
    r.kind = KindSpot;
    r.dir_x = CosW'(CosOne);
    r.reach_radius = 23'd1000;
    r.cos_outer = CosW'(CosOne / 2);
    r.rotation_limit = CosW'(CosOne);
    r.point_x = -24'sd100;                 // delta along +x, inside cone
    send_request(r);
    r.point_x = 24'sd100;                  // behind the light
    send_request(r);
    r.reach_radius = '0;                   // zero radius never reaches
    send_request(r);
    r.reach_radius = '1;
    r.kind = KindOmni;                     // omni always reaches inside radius
    send_request(r);
    r.kind = KindSpot;
    r.rotation_limit = CosW'(-CosOne / 2); // rotation limit at minus outer cosine
    send_request(r);
    r.rotation_limit = '0;                 // widened cosine non-positive
    send_request(r);
    r.point_x = -24'sd100;
    send_request(r);
    r.cos_outer = 16'sh7fff;               // cosines beyond one saturate
    r.rotation_limit = 16'sh8000;
    send_request(r);
    r.cos_outer = CosW'(CosOne - 10);
    r.rotation_limit = CosW'(CosOne - 10);
    send_request(r);
    // coordinate extremes: far corners, out of any radius, then a point beside the corner light
    r.light_x = 24'sh7fffff; r.light_y = 24'sh7fffff; r.light_z = 24'sh7fffff;
    r.point_x = 24'sh800000; r.point_y_and_z = {24'sh800000, 24'sh800000};
    r.dir_x = CosW'(-CosOne); r.dir_y = CosW'(CosOne); r.dir_z = CosW'(-CosOne);
    send_request(r);
    r.point_x = 24'sh7fffff; r.point_y_and_z = {24'sh7fffff, 24'sh7ffffe};
    send_request(r);
    r.kind = KindOmni;
    send_request(r);

    // hold off until the pipeline is empty
    in_valid <= 1'b0;
    wait_drained();
    @(posedge clk);

    for (int i = 0; i < 500; i++) begin
      no_idle = (i >= 200 && i < 300);
      send_request(rand_request());
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d light/point requests (%0d omni, %0d wide rotation), %0d results checked",
             n_sent, n_omni, n_wide, sb.checked);
    $display("stalls and gaps on both channels, with one unbroken burst and one full drain");
    if (sb.mismatches == 0 && sb.pending_reach.size() == 0) begin
      $display("tb_spot_light_reach_test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_reach.size());
      $display("tb_spot_light_reach_test: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 200000);
    $display("timeout waiting for results");
    $display("tb_spot_light_reach_test: errors");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/slrt_pkg.sv
hw/rtl/slrt_mul.sv
hw/rtl/slrt_isqrt.sv
hw/rtl/spot_light_reach_test.sv
dv/tb_spot_light_reach_test.sv
